// File: design/aml_pkg.sv
// shared types, codes and constants for the aggregate member layout block
package aml_pkg;

    localparam int MAX_MEMBERS_DEF = 65536;
    localparam int MIDQ_DEPTH_DEF  = 2;
    localparam int OUTQ_DEPTH_DEF  = 4;

    localparam logic [1:0] MODE_STRUCT  = 2'd0;
    localparam logic [1:0] MODE_UNION   = 2'd1;
    localparam logic [1:0] MODE_VARIANT = 2'd2;

    localparam logic [1:0] KIND_PACKED = 2'd1;
    localparam logic [1:0] KIND_BITF   = 2'd2;

    // operation decided by the front end
    localparam logic [1:0] OP_MAX   = 2'd0;
    localparam logic [1:0] OP_DISC  = 2'd1;
    localparam logic [1:0] OP_BITF  = 2'd2;
    localparam logic [1:0] OP_PLACE = 2'd3;

    localparam logic [1:0] ST_COMPLETE = 2'd0;
    localparam logic [1:0] ST_WAIT     = 2'd1;
    localparam logic [1:0] ST_OVF      = 2'd2;

    localparam logic RK_MEMBER  = 1'b0;
    localparam logic RK_SUMMARY = 1'b1;

    typedef struct packed {
        logic [63:0] member_size;
        logic [31:0] member_alignment;
        logic        layout_known;
        logic [1:0]  field_kind;
        logic [31:0] bf_width;
        logic        last_member;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] member_number;
        logic [63:0] byte_offset;
        logic [63:0] bit_offset;
        logic        member_missing;
        logic [1:0]  layout_status;
        logic [63:0] total_size;
        logic [31:0] total_alignment;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic [1:0]  op;
        logic        variant;
        logic        known;
        logic        last;
        logic [63:0] size;
        logic [31:0] align;
        logic [31:0] mask;
        logic [31:0] bw;
    } t_mid;

endpackage

// File: design/aml_queue.sv
// small register queue, one or two writes and one read per cycle
module aml_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_a,
    input  logic [WIDTH-1:0] i_data_a,
    input  logic             i_push_b,
    input  logic [WIDTH-1:0] i_data_b,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full,
    output logic             o_room2
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr, n_wptr;
    logic [PW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [PW-1:0]    wptr_1;
    logic             pop_ok;

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_room2 = (r_cnt <= CW'(DEPTH - 2));
    assign o_data  = r_mem[r_rptr];
    assign pop_ok  = i_pop && !o_empty;
    assign wptr_1  = inc(r_wptr);

    always_comb begin
        n_wptr = r_wptr;
        if (i_push_a && i_push_b) begin
            n_wptr = inc(wptr_1);
        end else if (i_push_a) begin
            n_wptr = wptr_1;
        end
        n_rptr = pop_ok ? inc(r_rptr) : r_rptr;
        n_cnt  = r_cnt + CW'(i_push_a) + CW'(i_push_a && i_push_b) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wptr] <= i_data_a;
        end
        if (i_push_a && i_push_b) begin
            r_mem[wptr_1] <= i_data_b;
        end
    end

endmodule

// File: design/aml_front.sv
// front end: mode register, input register, alignment cleanup and member classification
module aml_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  aml_pkg::t_in_item i_item,
    output logic             o_full,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_data,
    output logic             o_mid_push,
    output aml_pkg::t_mid    o_mid,
    input  logic             i_mid_full
);

    logic          r_valid;
    logic          r_first;
    logic [1:0]    r_mode;
    aml_pkg::t_mid r_mid, n_mid;
    logic          accept;
    logic [31:0]   al_norm;

    function automatic logic [31:0] norm_align(input logic [31:0] a);
        logic [31:0] s;
        s = a;
        s = s | (s >> 1);
        s = s | (s >> 2);
        s = s | (s >> 4);
        s = s | (s >> 8);
        s = s | (s >> 16);
        s = s ^ (s >> 1);
        return (a == 32'd0) ? 32'd1 : s;
    endfunction

    assign o_full     = r_valid && i_mid_full;
    assign accept     = i_push && !o_full;
    assign o_mid_push = r_valid && !i_mid_full;
    assign o_mid      = r_mid;
    assign al_norm    = norm_align(i_item.member_alignment);

    always_comb begin
        n_mid         = '0;
        n_mid.variant = (r_mode == aml_pkg::MODE_VARIANT);
        n_mid.known   = i_item.layout_known;
        n_mid.last    = i_item.last_member;
        n_mid.size    = i_item.member_size;
        n_mid.bw      = i_item.bf_width;
        n_mid.align   = al_norm;
        unique case (r_mode)
            aml_pkg::MODE_UNION: begin
                n_mid.op = aml_pkg::OP_MAX;
            end
            aml_pkg::MODE_VARIANT: begin
                n_mid.op = r_first ? aml_pkg::OP_DISC : aml_pkg::OP_MAX;
            end
            default: begin
                if (i_item.field_kind == aml_pkg::KIND_BITF) begin
                    n_mid.op = aml_pkg::OP_BITF;
                end else begin
                    n_mid.op = aml_pkg::OP_PLACE;
                    if (i_item.field_kind == aml_pkg::KIND_PACKED) begin
                        n_mid.align = 32'd1;
                    end
                end
            end
        endcase
        n_mid.mask = n_mid.align - 32'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_first <= 1'b1;
            r_mode  <= aml_pkg::MODE_STRUCT;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (accept) begin
                r_valid <= 1'b1;
                r_first <= i_item.last_member;
            end else if (!i_mid_full) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mid <= n_mid;
        end
    end

endmodule

// File: design/aml_back.sv
// back end: running layout state, member offsets and pipelined aggregate summary
module aml_back #(
    parameter int MAX_MEMBERS = aml_pkg::MAX_MEMBERS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_mid_valid,
    input  aml_pkg::t_mid    i_mid,
    output logic             o_mid_pop,
    input  logic             i_room2,
    output logic             o_push_a,
    output aml_pkg::t_result o_res_a,
    output logic             o_push_b,
    output aml_pkg::t_result o_res_b
);

    localparam int CW = $clog2(MAX_MEMBERS);

    typedef struct packed {
        logic             valid;
        aml_pkg::t_result mem;
        logic             sum;
        logic             variant;
        logic             miss;
        logic             ovf;
        logic [15:0]      num;
        logic [63:0]      rs;
        logic [31:0]      ra;
        logic [63:0]      ds;
        logic [31:0]      da;
    } t_sa;

    typedef struct packed {
        logic             valid;
        aml_pkg::t_result mem;
        logic             sum;
        logic             variant;
        logic             miss;
        logic             ovf;
        logic [15:0]      num;
        logic [31:0]      ra;
        logic [31:0]      da;
        logic [63:0]      rp;
        logic [63:0]      po;
        logic             ok_rp;
        logic             ok_po;
    } t_sb;

    typedef struct packed {
        logic             valid;
        aml_pkg::t_result mem;
        logic             sum;
        logic             variant;
        logic             miss;
        logic             ovf;
        logic [15:0]      num;
        logic [31:0]      ra;
        logic [63:0]      rp;
        logic [63:0]      po;
        logic [31:0]      a;
        logic [63:0]      s;
        logic             ok_pre;
    } t_sc;

    function automatic logic [64:0] align_up(input logic [63:0] v, input logic [31:0] a);
        logic [63:0] m;
        logic [64:0] s;
        m = {32'd0, a - 32'd1};
        s = {1'b0, v} + {1'b0, m};
        return {s[64], s[63:0] & ~m};
    endfunction

    logic [63:0]   r_bp, n_bp;
    logic [63:0]   r_nb, n_nb;
    logic [63:0]   r_rs, n_rs;
    logic [31:0]   r_ra, n_ra;
    logic [63:0]   r_ds, n_ds;
    logic [31:0]   r_da, n_da;
    logic          r_miss, n_miss;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_cnt, n_cnt;

    t_sa r_a, n_a;
    t_sb r_b, n_b;
    t_sc r_c, n_c;

    logic          en;
    logic          take;
    logic [63:0]   m_boff, m_bit;
    logic [64:0]   bf_sum;
    logic [65:0]   bf_s7;
    logic [63:0]   bf_nb;
    logic          bf_bad;
    logic [63:0]   pl_mask;
    logic [64:0]   pl_s1;
    logic [63:0]   pl_off;
    logic [64:0]   pl_s2;
    logic          pl_bad;
    logic [CW+15:0] num_ext, sum_num_ext;
    logic [64:0]   rp_r, po_r, fin_r;
    logic [64:0]   c_sum;
    logic          ok_fin;
    aml_pkg::t_result summ;

    assign en        = !r_c.valid || i_room2;
    assign take      = en && i_mid_valid;
    assign o_mid_pop = take;

    // bit-field placement
    assign bf_sum = {1'b0, r_bp} + {33'd0, i_mid.bw};
    assign bf_bad = (i_mid.bw == 32'd0) || bf_sum[64];
    assign bf_s7  = {2'b00, r_bp} + {34'd0, i_mid.bw} + 66'd7;
    assign bf_nb  = {1'b0, bf_s7[65:3]};

    // byte placement: close the open byte, align, add the size
    assign pl_mask = {32'd0, i_mid.mask};
    assign pl_s1   = {1'b0, r_nb} + {1'b0, pl_mask};
    assign pl_off  = pl_s1[63:0] & ~pl_mask;
    assign pl_s2   = {1'b0, pl_off} + {1'b0, i_mid.size};
    assign pl_bad  = pl_s1[64] || pl_s2[64] || (|pl_off[63:61]) || (|pl_s2[63:61]);

    always_comb begin
        n_bp   = r_bp;
        n_nb   = r_nb;
        n_rs   = r_rs;
        n_ra   = r_ra;
        n_ds   = r_ds;
        n_da   = r_da;
        n_miss = r_miss;
        n_ovf  = r_ovf;
        m_boff = '0;
        m_bit  = '0;
        if (!i_mid.known) begin
            n_miss = 1'b1;
        end else if (!r_ovf) begin
            unique case (i_mid.op)
                aml_pkg::OP_MAX: begin
                    if (i_mid.size > r_rs) begin
                        n_rs = i_mid.size;
                    end
                    if (i_mid.align > r_ra) begin
                        n_ra = i_mid.align;
                    end
                end
                aml_pkg::OP_DISC: begin
                    n_ds = i_mid.size;
                    n_da = i_mid.align;
                end
                aml_pkg::OP_BITF: begin
                    if (bf_bad) begin
                        n_ovf = 1'b1;
                    end else begin
                        m_boff = {3'd0, r_bp[63:3]};
                        m_bit  = r_bp;
                        n_bp   = bf_sum[63:0];
                        n_nb   = bf_nb;
                        n_rs   = bf_nb;
                    end
                end
                aml_pkg::OP_PLACE: begin
                    if (pl_bad) begin
                        n_ovf = 1'b1;
                    end else begin
                        m_boff = pl_off;
                        m_bit  = {pl_off[60:0], 3'd0};
                        n_rs   = pl_s2[63:0];
                        n_nb   = pl_s2[63:0];
                        n_bp   = {pl_s2[60:0], 3'd0};
                        if (i_mid.align > r_ra) begin
                            n_ra = i_mid.align;
                        end
                    end
                end
            endcase
        end
        n_cnt = (r_cnt == CW'(MAX_MEMBERS - 1)) ? '0 : r_cnt + CW'(1);
    end

    assign num_ext     = {16'd0, r_cnt};
    assign sum_num_ext = {16'd0, n_cnt};

    // member result and summary snapshot
    always_comb begin
        n_a                     = '0;
        n_a.valid               = take;
        n_a.mem.result_kind     = aml_pkg::RK_MEMBER;
        n_a.mem.member_number   = num_ext[15:0];
        n_a.mem.byte_offset     = m_boff;
        n_a.mem.bit_offset      = m_bit;
        n_a.mem.member_missing  = !i_mid.known;
        n_a.mem.layout_status   = aml_pkg::ST_COMPLETE;
        n_a.mem.total_size      = '0;
        n_a.mem.total_alignment = 32'd1;
        n_a.mem.last_result     = !i_mid.last;
        n_a.sum                 = i_mid.last;
        n_a.variant             = i_mid.variant;
        n_a.miss                = n_miss;
        n_a.ovf                 = n_ovf;
        n_a.num                 = sum_num_ext[15:0];
        n_a.rs                  = n_rs;
        n_a.ra                  = n_ra;
        n_a.ds                  = n_ds;
        n_a.da                  = n_da;
    end

    // summary step one: round payload and discriminator
    assign rp_r = align_up(r_a.rs, r_a.ra);
    assign po_r = align_up(r_a.ds, r_a.ra);

    always_comb begin
        n_b         = '0;
        n_b.valid   = r_a.valid;
        n_b.mem     = r_a.mem;
        n_b.sum     = r_a.sum;
        n_b.variant = r_a.variant;
        n_b.miss    = r_a.miss;
        n_b.ovf     = r_a.ovf;
        n_b.num     = r_a.num;
        n_b.ra      = r_a.ra;
        n_b.da      = r_a.da;
        n_b.rp      = rp_r[63:0];
        n_b.po      = po_r[63:0];
        n_b.ok_rp   = !rp_r[64];
        n_b.ok_po   = !po_r[64];
    end

    // summary step two: payload end and aggregate alignment
    assign c_sum = {1'b0, r_b.po} + {1'b0, r_b.rp};

    always_comb begin
        n_c         = '0;
        n_c.valid   = r_b.valid;
        n_c.mem     = r_b.mem;
        n_c.sum     = r_b.sum;
        n_c.variant = r_b.variant;
        n_c.miss    = r_b.miss;
        n_c.ovf     = r_b.ovf;
        n_c.num     = r_b.num;
        n_c.ra      = r_b.ra;
        n_c.rp      = r_b.rp;
        n_c.po      = r_b.po;
        n_c.a       = (r_b.da > r_b.ra) ? r_b.da : r_b.ra;
        n_c.s       = c_sum[63:0];
        if (r_b.variant) begin
            n_c.ok_pre = r_b.ok_rp && r_b.ok_po && !c_sum[64] && !(|r_b.po[63:61]);
        end else begin
            n_c.ok_pre = r_b.ok_rp;
        end
    end

    // summary step three: final round and status
    assign fin_r  = align_up(r_c.s, r_c.a);
    assign ok_fin = !r_c.ovf && r_c.ok_pre && (!r_c.variant || !fin_r[64]);

    always_comb begin
        summ                 = '0;
        summ.result_kind     = aml_pkg::RK_SUMMARY;
        summ.member_number   = r_c.num;
        summ.member_missing  = r_c.miss;
        summ.last_result     = 1'b1;
        summ.total_alignment = 32'd1;
        if (r_c.miss) begin
            summ.layout_status = aml_pkg::ST_WAIT;
        end else if (!ok_fin) begin
            summ.layout_status = aml_pkg::ST_OVF;
        end else begin
            summ.layout_status = aml_pkg::ST_COMPLETE;
            if (r_c.variant) begin
                summ.total_size      = fin_r[63:0];
                summ.total_alignment = r_c.a;
                summ.byte_offset     = r_c.po;
                summ.bit_offset      = {r_c.po[60:0], 3'd0};
            end else begin
                summ.total_size      = r_c.rp;
                summ.total_alignment = r_c.ra;
            end
        end
    end

    assign o_push_a = r_c.valid && en;
    assign o_push_b = r_c.valid && en && r_c.sum;
    assign o_res_a  = r_c.mem;
    assign o_res_b  = summ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bp    <= '0;
            r_nb    <= '0;
            r_rs    <= '0;
            r_ra    <= 32'd1;
            r_ds    <= '0;
            r_da    <= 32'd1;
            r_miss  <= 1'b0;
            r_ovf   <= 1'b0;
            r_cnt   <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
        end else begin
            if (take) begin
                if (i_mid.last) begin
                    r_bp   <= '0;
                    r_nb   <= '0;
                    r_rs   <= '0;
                    r_ra   <= 32'd1;
                    r_ds   <= '0;
                    r_da   <= 32'd1;
                    r_miss <= 1'b0;
                    r_ovf  <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_bp   <= n_bp;
                    r_nb   <= n_nb;
                    r_rs   <= n_rs;
                    r_ra   <= n_ra;
                    r_ds   <= n_ds;
                    r_da   <= n_da;
                    r_miss <= n_miss;
                    r_ovf  <= n_ovf;
                    r_cnt  <= n_cnt;
                end
            end
            if (en) begin
                r_a <= n_a;
                r_b <= n_b;
                r_c <= n_c;
            end
        end
    end

endmodule

// File: design/aggregate_member_layout.sv
// aggregate member layout: offsets per member, summary on the last
// path: input register, middle queue, back-end stages a, b, c, then the result queue
// throughput: one item per cycle unless the result queue lacks room for two; a last
// member adds a summary; the rate is set by the running-state update in the back end
// reset is synchronous, active low: queues empty, layout state cleared, mode set to struct
module aggregate_member_layout #(
    parameter int MAX_MEMBERS = aml_pkg::MAX_MEMBERS_DEF,
    parameter int MIDQ_DEPTH  = aml_pkg::MIDQ_DEPTH_DEF,
    parameter int OUTQ_DEPTH  = aml_pkg::OUTQ_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  aml_pkg::t_in_item i_item,
    input  logic              pop,
    output logic              empty,
    output aml_pkg::t_result  o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_data
);

    localparam int MW = $bits(aml_pkg::t_mid);
    localparam int RW = $bits(aml_pkg::t_result);

    logic             mid_push;
    aml_pkg::t_mid    mid_in;
    aml_pkg::t_mid    mid_out;
    logic             mid_full;
    logic             mid_empty;
    logic             mid_pop;
    logic             mid_room2;
    logic             out_push_a;
    logic             out_push_b;
    aml_pkg::t_result out_res_a;
    aml_pkg::t_result out_res_b;
    logic             out_full;
    logic             out_room2;

    aml_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (i_item),
        .o_full     (full),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_mid_push (mid_push),
        .o_mid      (mid_in),
        .i_mid_full (mid_full)
    );

    aml_queue #(
        .WIDTH (MW),
        .DEPTH (MIDQ_DEPTH)
    ) u_midq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (mid_push),
        .i_data_a (mid_in),
        .i_push_b (1'b0),
        .i_data_b ('0),
        .i_pop    (mid_pop),
        .o_data   (mid_out),
        .o_empty  (mid_empty),
        .o_full   (mid_full),
        .o_room2  (mid_room2)
    );

    aml_back #(
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (!mid_empty),
        .i_mid       (mid_out),
        .o_mid_pop   (mid_pop),
        .i_room2     (out_room2),
        .o_push_a    (out_push_a),
        .o_res_a     (out_res_a),
        .o_push_b    (out_push_b),
        .o_res_b     (out_res_b)
    );

    aml_queue #(
        .WIDTH (RW),
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (out_push_a),
        .i_data_a (out_res_a),
        .i_push_b (out_push_b),
        .i_data_b (out_res_b),
        .i_pop    (pop),
        .o_data   (o_result),
        .o_empty  (empty),
        .o_full   (out_full),
        .o_room2  (out_room2)
    );

endmodule
